>>> rtl/ths_pkg.sv
// ----------------------------------------------------------------------------
// ths_pkg
// Types and constants shared by the timer heap scheduler files.
// ----------------------------------------------------------------------------
package ths_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int MAX_RESULTS      = 64;
   localparam int TIME_W           = 48;
   localparam int PERIOD_W         = 34;
   localparam int US_PER_MS        = 1000;

   typedef enum logic [1:0] {
      KIND_FIRED    = 2'd0,
      KIND_ACCEPTED = 2'd1,
      KIND_REJECTED = 2'd2
   } kind_type;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0]   deadline;
      logic [PERIOD_W-1:0] period;
      logic signed [31:0]  session;
      logic [15:0]         remaining;
   } entry_type;

endpackage

>>> rtl/ths_mem.sv
// ----------------------------------------------------------------------------
// ths_mem
// Heap entry store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module ths_mem #(
   parameter int DEPTH = 65,
   parameter int AW    = 7
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  ths_pkg::entry_type  wr_data,
   input  logic [AW-1:0]       rd_addr_a,
   input  logic [AW-1:0]       rd_addr_b,
   output ths_pkg::entry_type  rd_data_a,
   output ths_pkg::entry_type  rd_data_b
);
   import ths_pkg::*;

   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

>>> rtl/timer_heap_scheduler_core.sv
// ----------------------------------------------------------------------------
// timer_heap_scheduler_core
// Timer queue kept as a binary min-heap on deadline in one entry memory.
// ----------------------------------------------------------------------------
// A push works out the period, adds it to the time for the deadline, then climbs
// the heap a level at a time until its parent is not later, and answers with one
// word; a full queue rejects the push without touching the heap. A tick inspects
// the root timer by timer; each timer fired is re-armed and sifted down from the
// root, or removed, the last entry then moved to the root and sifted down. Every
// heap level costs one read of the entry memory and a compare. A stalled result
// word holds the tick or the final answer until it is taken. One item is worked
// on at a time.
module timer_heap_scheduler_core #(
   parameter int CAPACITY = ths_pkg::CAPACITY_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic [47:0]        req_now_us,
   input  logic signed [31:0] req_session,
   input  logic [23:0]        req_interval_ms,
   input  logic [15:0]        req_repeat_count,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic signed [31:0] rsp_out_session,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic [6:0]         csr_write_data
);
   import ths_pkg::*;

   localparam int AW    = $clog2(CAPACITY + 1);
   localparam int KW    = AW + 1;
   localparam int DEPTH = CAPACITY + 1;

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_P_CALC = 12'b000000000010,
      S_P_ADD  = 12'b000000000100,
      S_P_RD   = 12'b000000001000,
      S_P_CMP  = 12'b000000010000,
      S_T_RD   = 12'b000000100000,
      S_T_CHK  = 12'b000001000000,
      S_T_LAST = 12'b000010000000,
      S_T_MOVE = 12'b000100000000,
      S_SD_RD  = 12'b001000000000,
      S_SD_CMP = 12'b010000000000,
      S_FIN    = 12'b100000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [AW-1:0]      count_ff, count_in;
   logic [KW-1:0]      k_ff, k_in;
   entry_type          held_ff, held_in;
   logic [6:0]         max_fires_ff;
   logic [6:0]         fired_ff, fired_in;
   logic [47:0]        now_ff;
   logic signed [31:0] sess_ff;
   logic [23:0]        ivl_ff;
   logic [15:0]        reps_ff;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic               pend_v_ff, pend_v_in;
   kind_type           pend_kind_ff, pend_kind_in;
   logic signed [31:0] pend_sess_ff, pend_sess_in;
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic signed [31:0] rsp_sess_ff, rsp_sess_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               mem_we;
   logic [AW-1:0]      mem_waddr, rd_addr_a, rd_addr_b;
   entry_type          mem_wdata, rd_a, rd_b;

   logic               accept, out_free;
   logic [6:0]         limit;
   logic [KW-1:0]      child, count_k;
   logic               use_b;
   entry_type          pick;

   ths_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   assign req_ready       = (state_ff == S_IDLE);
   assign accept          = req_valid && req_ready;
   assign out_free        = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_session = rsp_sess_ff;
   assign rsp_last        = rsp_last_ff;

   assign limit   = (max_fires_ff == 7'd0) ? 7'd1 :
                    (max_fires_ff > 7'(MAX_RESULTS)) ? 7'(MAX_RESULTS) : max_fires_ff;
   assign child   = KW'(k_ff << 1);
   assign count_k = KW'(count_ff);
   assign use_b   = (child + KW'(1) <= count_k) && (rd_a.deadline > rd_b.deadline);
   assign pick    = use_b ? rd_b : rd_a;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      held_in      = held_ff;
      fired_in     = fired_ff;
      period_in    = period_ff;
      pend_v_in    = pend_v_ff;
      pend_kind_in = pend_kind_ff;
      pend_sess_in = pend_sess_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_sess_in  = rsp_sess_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = k_ff[AW-1:0];
      mem_wdata    = held_ff;
      rd_addr_a    = AW'(1);
      rd_addr_b    = AW'(1);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               fired_in = 7'd0;
               if (req_cmd == CMD_TICK) begin
                  state_in = S_T_RD;
               end else if (KW'(count_ff) >= KW'(CAPACITY)) begin
                  pend_v_in    = 1'b1;
                  pend_kind_in = KIND_REJECTED;
                  pend_sess_in = req_session;
                  state_in     = S_FIN;
               end else begin
                  state_in = S_P_CALC;
               end
            end
         end
         S_P_CALC: begin
            period_in = PERIOD_W'(PERIOD_W'(ivl_ff) * PERIOD_W'(US_PER_MS));
            state_in  = S_P_ADD;
         end
         S_P_ADD: begin
            held_in.period    = period_ff;
            held_in.deadline  = now_ff + TIME_W'(period_ff);
            held_in.session   = sess_ff;
            held_in.remaining = reps_ff;
            count_in          = count_ff + AW'(1);
            k_in              = KW'(count_ff) + KW'(1);
            pend_v_in         = 1'b1;
            pend_kind_in      = KIND_ACCEPTED;
            pend_sess_in      = sess_ff;
            state_in          = S_P_RD;
         end
         S_P_RD: begin
            if (k_ff == KW'(1)) begin
               mem_we   = 1'b1;
               state_in = S_FIN;
            end else begin
               rd_addr_a = AW'(k_ff >> 1);
               state_in  = S_P_CMP;
            end
         end
         S_P_CMP: begin
            mem_we = 1'b1;
            if (rd_a.deadline <= held_ff.deadline) begin
               state_in = S_FIN;
            end else begin
               mem_wdata = rd_a;
               k_in      = k_ff >> 1;
               state_in  = S_P_RD;
            end
         end
         S_T_RD: begin
            if (count_ff == AW'(0) || fired_ff >= limit) begin
               state_in = S_FIN;
            end else begin
               state_in = S_T_CHK;
            end
         end
         S_T_CHK: begin
            if (rd_a.deadline > now_ff) begin
               state_in = S_FIN;
            end else if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = pend_kind_ff;
                  rsp_sess_in  = pend_sess_ff;
                  rsp_last_in  = 1'b0;
               end
               pend_v_in    = 1'b1;
               pend_kind_in = KIND_FIRED;
               pend_sess_in = rd_a.session;
               fired_in     = fired_ff + 7'd1;
               if (rd_a.remaining != 16'd1) begin
                  // Re-arm: next deadline one period on, then sift down from the root.
                  held_in          = rd_a;
                  held_in.deadline = rd_a.deadline + TIME_W'(rd_a.period);
                  if (rd_a.remaining != 16'd0) begin
                     held_in.remaining = rd_a.remaining - 16'd1;
                  end
                  k_in     = KW'(1);
                  state_in = S_SD_RD;
               end else begin
                  state_in = S_T_LAST;
               end
            end
         end
         S_T_LAST: begin
            rd_addr_a = count_ff;
            state_in  = S_T_MOVE;
         end
         S_T_MOVE: begin
            // The last entry takes the root's place.
            count_in = count_ff - AW'(1);
            held_in  = rd_a;
            k_in     = KW'(1);
            if (count_ff > AW'(2)) begin
               state_in = S_SD_RD;
            end else begin
               if (count_ff == AW'(2)) begin
                  mem_we    = 1'b1;
                  mem_waddr = AW'(1);
                  mem_wdata = rd_a;
               end
               state_in = S_T_RD;
            end
         end
         S_SD_RD: begin
            if (child > count_k) begin
               mem_we   = 1'b1;
               state_in = S_T_RD;
            end else begin
               rd_addr_a = child[AW-1:0];
               rd_addr_b = (child + KW'(1) <= count_k) ?
                           AW'(child + KW'(1)) : child[AW-1:0];
               state_in  = S_SD_CMP;
            end
         end
         S_SD_CMP: begin
            mem_we = 1'b1;
            if (held_ff.deadline <= pick.deadline) begin
               state_in = S_T_RD;
            end else begin
               mem_wdata = pick;
               k_in      = use_b ? child + KW'(1) : child;
               state_in  = S_SD_RD;
            end
         end
         S_FIN: begin
            if (!pend_v_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_kind_ff;
               rsp_sess_in  = pend_sess_ff;
               rsp_last_in  = 1'b1;
               pend_v_in    = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         max_fires_ff <= 7'(MAX_RESULTS);
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            max_fires_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      held_ff      <= held_in;
      fired_ff     <= fired_in;
      period_ff    <= period_in;
      pend_kind_ff <= pend_kind_in;
      pend_sess_ff <= pend_sess_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_sess_ff  <= rsp_sess_in;
      rsp_last_ff  <= rsp_last_in;
      if (accept) begin
         now_ff  <= req_now_us;
         sess_ff <= req_session;
         ivl_ff  <= req_interval_ms;
         reps_ff <= req_repeat_count;
      end
   end

endmodule

>>> rtl/ths_checker.sv
// ----------------------------------------------------------------------------
// ths_checker
// Port-level checks for the timer heap scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module ths_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_kind,
   input logic signed [31:0] rsp_out_session,
   input logic               rsp_last
);
   import ths_pkg::*;

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_session) && $stable(rsp_kind))
      else $error("result word changed while stalled");

   // Push answers are always the single, final word of their item.
   a_push_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_FIRED |-> rsp_last)
      else $error("push answer without last");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind != 2'd3)
      else $error("illegal result kind");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word right after reset");

endmodule

bind timer_heap_scheduler_core ths_checker u_ths_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_kind        (rsp_kind),
   .rsp_out_session (rsp_out_session),
   .rsp_last        (rsp_last)
);
